>>> rtl/core/tsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants for the thread id slot assigner
// Field widths, result codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int KEY_W         = 32;
  localparam int SLOT_W        = 6;
  localparam int STATUS_W      = 2;
  localparam int HASH_STEPS    = 4;
  localparam int BITS_PER_STEP = KEY_W / HASH_STEPS;
  localparam int HASH_CNT_W    = $clog2(HASH_STEPS);

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND = 2'd0,
    STAT_NEW   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ZERO  = 2'd3
  } tsa_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK
  } tsa_state_t;

  typedef struct packed {
    logic        clr_wr;
    logic        load_key;
    logic        hash_step;
    logic        seed_pos;
    logic        rd_en;
    logic        advance;
    logic        wr_key;
    logic        reply;
    tsa_status_t reply_code;
  } tsa_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic key_zero;
    logic hash_last;
    logic hit;
    logic empty;
    logic probe_last;
  } tsa_sts_t;

endpackage

>>> rtl/core/tsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_datapath: key table, home slot reduction and probe pointer
// Holds the key table memory, reduces the key modulo the table size a byte
// per cycle, walks the probe pointer and registers the result.
// ----------------------------------------------------------------------------
module tsa_datapath #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tsa_pkg::tsa_cmd_t          cmd,
  output tsa_pkg::tsa_sts_t          sts,
  input  logic [tsa_pkg::KEY_W-1:0]  thread_key,
  output logic                       done,
  output logic [tsa_pkg::SLOT_W-1:0] slot_index,
  output logic [tsa_pkg::STATUS_W-1:0] status
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int RW    = IDX_W + 1;
  localparam logic [RW-1:0]    MOD_C    = RW'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  logic [tsa_pkg::KEY_W-1:0]      mem [TABLE_SIZE];
  logic [tsa_pkg::KEY_W-1:0]      rd_data;
  logic [tsa_pkg::KEY_W-1:0]      key;
  logic [tsa_pkg::KEY_W-1:0]      key_sh;
  logic [IDX_W-1:0]               rem;
  logic [IDX_W-1:0]               rem_next;
  logic [IDX_W-1:0]               pos;
  logic [IDX_W-1:0]               pos_inc;
  logic [IDX_W-1:0]               probe_cnt;
  logic [tsa_pkg::HASH_CNT_W-1:0] hash_cnt;
  logic [tsa_pkg::SLOT_W+IDX_W-1:0] slot_wide;

  // reduce one byte of the key into the running remainder
  always_comb begin
    logic [RW-1:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < tsa_pkg::BITS_PER_STEP; i++) begin
      t = {t[RW-2:0], key_sh[tsa_pkg::KEY_W-1-i]};
      if (t >= MOD_C) begin
        t = t - MOD_C;
      end
    end
    rem_next = t[IDX_W-1:0];
  end

  assign pos_inc   = (pos == LAST_IDX) ? '0 : pos + 1'b1;
  assign slot_wide = {{tsa_pkg::SLOT_W{1'b0}}, pos};

  assign sts.pos_last   = (pos == LAST_IDX);
  assign sts.key_zero   = (thread_key == '0);
  assign sts.hash_last  = (hash_cnt == tsa_pkg::HASH_CNT_W'(tsa_pkg::HASH_STEPS - 1));
  assign sts.hit        = (rd_data == key);
  assign sts.empty      = (rd_data == '0);
  assign sts.probe_last = (probe_cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[pos] <= '0;
    end else if (cmd.wr_key) begin
      mem[pos] <= key;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      probe_cnt <= '0;
      hash_cnt  <= '0;
    end else begin
      if (cmd.clr_wr || cmd.advance) begin
        pos <= pos_inc;
      end else if (cmd.seed_pos) begin
        pos <= rem_next;
      end
      if (cmd.seed_pos) begin
        probe_cnt <= '0;
      end else if (cmd.advance) begin
        probe_cnt <= probe_cnt + 1'b1;
      end
      if (cmd.load_key) begin
        hash_cnt <= '0;
      end else if (cmd.hash_step) begin
        hash_cnt <= hash_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key    <= thread_key;
      key_sh <= thread_key;
      rem    <= '0;
    end else if (cmd.hash_step) begin
      key_sh <= key_sh << tsa_pkg::BITS_PER_STEP;
      rem    <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.reply;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      status <= cmd.reply_code;
      if (cmd.reply_code == tsa_pkg::STAT_FOUND || cmd.reply_code == tsa_pkg::STAT_NEW) begin
        slot_index <= slot_wide[tsa_pkg::SLOT_W-1:0];
      end else begin
        slot_index <= '0;
      end
    end
  end

endmodule

>>> rtl/core/tsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_ctrl: sequencer for the thread id slot assigner
// Runs the clearing pass after reset, then per item: reduce the key, probe
// the table one slot at a time and issue the reply; a zero key is replied to from idle.
// ----------------------------------------------------------------------------
module tsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsa_pkg::tsa_sts_t sts,
  output tsa_pkg::tsa_cmd_t cmd
);

  tsa_pkg::tsa_state_t state;
  tsa_pkg::tsa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tsa_pkg::ST_CLEAR: begin
        if (sts.pos_last) state_next = tsa_pkg::ST_IDLE;
      end
      tsa_pkg::ST_IDLE: begin
        if (start && !sts.key_zero) state_next = tsa_pkg::ST_HASH;
      end
      tsa_pkg::ST_HASH: begin
        if (sts.hash_last) state_next = tsa_pkg::ST_READ;
      end
      tsa_pkg::ST_READ: begin
        state_next = tsa_pkg::ST_CHECK;
      end
      tsa_pkg::ST_CHECK: begin
        if (sts.hit || sts.empty || sts.probe_last) begin
          state_next = tsa_pkg::ST_IDLE;
        end else begin
          state_next = tsa_pkg::ST_READ;
        end
      end
      default: state_next = tsa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.reply_code = tsa_pkg::STAT_FOUND;
    busy           = 1'b1;
    unique case (state)
      tsa_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      tsa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_key = 1'b1;
          if (sts.key_zero) begin
            cmd.reply      = 1'b1;
            cmd.reply_code = tsa_pkg::STAT_ZERO;
          end
        end
      end
      tsa_pkg::ST_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.seed_pos  = sts.hash_last;
      end
      tsa_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      tsa_pkg::ST_CHECK: begin
        if (sts.hit) begin
          cmd.reply      = 1'b1;
          cmd.reply_code = tsa_pkg::STAT_FOUND;
        end else if (sts.empty) begin
          cmd.wr_key     = 1'b1;
          cmd.reply      = 1'b1;
          cmd.reply_code = tsa_pkg::STAT_NEW;
        end else if (sts.probe_last) begin
          cmd.reply      = 1'b1;
          cmd.reply_code = tsa_pkg::STAT_FULL;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        cmd.clr_wr = 1'b0;
      end
    endcase
  end

  a_reply_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.reply |=> state == tsa_pkg::ST_IDLE)
    else $error("reply not followed by idle");

  a_store_only_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_key |-> (sts.empty && !sts.hit && state == tsa_pkg::ST_CHECK))
    else $error("key stored into occupied slot");

  a_no_advance_past_end: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> !sts.probe_last)
    else $error("probe walked past table size");

  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    state == tsa_pkg::ST_CHECK |-> $past(cmd.rd_en))
    else $error("check without a preceding read");

  a_one_memory_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.wr_key, cmd.rd_en}))
    else $error("more than one memory operation");

endmodule

>>> rtl/core/thread_id_slot_assigner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_id_slot_assigner: find-or-assign a slot for a thread key
// Open-addressed key table with linear probing from the key's home slot
// (key modulo TABLE_SIZE), wrapping to slot 0. A zero entry is empty.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   request  | start / busy       | thread_key[31:0]
//   result   | done (one cycle)   | slot_index[5:0], status[1:0]
//
// Timing: a zero key replies the cycle after it is taken. Any other key
//   first reduces its home slot one key byte per cycle, then probes with a
//   memory read and a compare per slot, and the result is registered onto
//   done. One item at a time.
// Reset: the table is swept to zero, one entry per cycle, after reset;
//   busy stays high meanwhile.
// Stalls: the receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module thread_id_slot_assigner #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tsa_pkg::KEY_W-1:0]    thread_key,
  output logic                         done,
  output logic [tsa_pkg::SLOT_W-1:0]   slot_index,
  output logic [tsa_pkg::STATUS_W-1:0] status
);

  tsa_pkg::tsa_cmd_t cmd;
  tsa_pkg::tsa_sts_t sts;

  tsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tsa_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .thread_key (thread_key),
    .done       (done),
    .slot_index (slot_index),
    .status     (status)
  );

endmodule
